// ===== hdl/gray_downscale_to_char_levels_macros.svh =====
// Assertion macros shared by the checker of the character-level downscaler.
`ifndef GRAY_DOWNSCALE_TO_CHAR_LEVELS_MACROS_SVH
`define GRAY_DOWNSCALE_TO_CHAR_LEVELS_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, quiet in reset
`define GDC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, quiet in reset
`define GDC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/gdc_pkg.sv =====
// Shared types, constants and register codes of the character-level downscaler.
`timescale 1ns / 1ps
`default_nettype none

package gdc_pkg;

   // Image limits and ramp size
   localparam int MAX_OUT_DIM = 255;
   localparam int MAX_SRC_DIM = 4096;
   localparam int LEVEL_COUNT = 9;

   // Luma store
   localparam int STORE_DEPTH = 65536;
   localparam int STORE_AW    = 16;
   localparam int LUMA_W      = 8;

   // Field and counter widths
   localparam int DIM_W   = 13;
   localparam int OUT_W   = 8;
   localparam int LEVEL_W = 4;

   // Shared divider operand widths
   localparam int DIVIDEND_W = 22;
   localparam int DIVISOR_W  = 13;

   // Configuration port
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   // Register indexes
   localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
   localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
   localparam logic [1:0] REG_OUT_WIDTH  = 2'd2;
   localparam logic [1:0] REG_CLAMP_MODE = 2'd3;

   // Register reset values
   localparam logic [DIM_W-1:0] SRC_WIDTH_RST  = 13'd1;
   localparam logic [DIM_W-1:0] SRC_HEIGHT_RST = 13'd1;
   localparam logic [OUT_W-1:0] OUT_WIDTH_RST  = 8'd90;
   localparam logic             CLAMP_MODE_RST = 1'b1;

   // Item function codes
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_FETCH = 1'b1;

   // Luma (r+g+b)/3 as multiply by reciprocal and shift
   localparam logic [9:0] LUMA_RECIP = 10'd683;
   localparam int         LUMA_SHIFT = 11;

   // Full-scale luma and level scale factor
   localparam logic [LUMA_W-1:0] LUMA_MAX    = 8'd255;
   localparam logic [OUT_W-1:0]  LEVEL_SCALE = OUT_W'(LEVEL_COUNT - 1);

   typedef struct packed {
      logic       func;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               row_end;
      logic               last;
      logic               no_data;
   } rsp_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== hdl/gdc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module gdc_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/gdc_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module gdc_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  gdc_pkg::div_req_type div_req,
   output gdc_pkg::div_rsp_type div_rsp
);

   import gdc_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W:0]    rem_sh;
   logic [DIVISOR_W:0]    rem_diff;

   // one shift-and-subtract step per cycle
   always_comb begin
      rem_sh   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      rem_diff = rem_sh - {1'b0, div_req.divisor};
      run_in   = run_ff;
      cnt_in   = cnt_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      if (div_req.start) begin
         quo_in = div_req.dividend;
         rem_in = '0;
         cnt_in = CNT_W'(DIVIDEND_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!rem_diff[DIVISOR_W]) begin
            rem_in = rem_diff[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

// ===== hdl/gray_downscale_to_char_levels.sv =====
// Top level: sequencer that downsamples a streamed image into character levels.
//
//   channel   ports                               beat taken when
//   --------  ----------------------------------  ---------------------------
//   request   start, busy, req_item               start high, busy low
//   result    rsp_strobe, rsp_item                rsp_strobe high (one cycle)
//   config    psel penable pwrite paddr pwdata    psel, penable, pwrite high
//             prdata pready (always high)
//
// Divisions share one bit-serial divider (22 quotient bits). Load: one division if it
// keeps a pixel that is not the row's last sampled column; the first load of a source
// row, or after a register write, adds up to 4 divisions. Fetch: a store read, plus one
// division when the luma range is not flat; a no_data answer reads no store.
// The first item after a register write adds one division for the output height.
// Synchronous reset; no store clearing. Results cannot stall: one cycle each, as busy falls.
`timescale 1ns / 1ps
`default_nettype none

module gray_downscale_to_char_levels (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  gdc_pkg::req_type             req_item,
   output logic                         rsp_strobe,
   output gdc_pkg::rsp_type             rsp_item,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [gdc_pkg::CSR_AW-1:0]   paddr,
   input  logic [gdc_pkg::CSR_DW-1:0]   pwdata,
   output logic [gdc_pkg::CSR_DW-1:0]   prdata,
   output logic                         pready
);

   import gdc_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_GEO_MUL,
      ST_GEO_DIV,
      ST_DISPATCH,
      ST_ROW_MUL1,
      ST_ROW_DIV1,
      ST_ROW_MUL2,
      ST_ROW_DIV2,
      ST_ROW_BASE,
      ST_COL_MUL1,
      ST_COL_DIV1,
      ST_COL_MUL2,
      ST_COL_DIV2,
      ST_LOAD,
      ST_FETCH,
      ST_FETCH_RD,
      ST_FETCH_DIV
   } state_type;

   // control registers
   state_type           state_ff, state_in;
   logic [DIM_W-1:0]    sw_cfg_ff, sw_cfg_in;
   logic [DIM_W-1:0]    sh_cfg_ff, sh_cfg_in;
   logic [OUT_W-1:0]    ow_cfg_ff, ow_cfg_in;
   logic                clamp_ff, clamp_in;
   logic                geo_dirty_ff, geo_dirty_in;
   logic                track_ok_ff, track_ok_in;
   logic                row_ok_ff, row_ok_in;
   logic                col_ok_ff, col_ok_in;
   logic                adv_ff, adv_in;
   logic [LUMA_W-1:0]   min_ff, min_in;
   logic [LUMA_W-1:0]   max_ff, max_in;
   logic [DIM_W-1:0]    load_row_ff, load_row_in;
   logic [DIM_W-1:0]    load_col_ff, load_col_in;
   logic [OUT_W-1:0]    read_row_ff, read_row_in;
   logic [OUT_W-1:0]    read_col_ff, read_col_in;
   logic                loaded_ff, loaded_in;
   logic                done_ff, done_in;
   logic [OUT_W-1:0]    oh_ff, oh_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic                div_go_ff, div_go_in;

   // datapath registers
   req_type               item_ff, item_in;
   rsp_type               rsp_item_ff, rsp_item_in;
   logic [DIVIDEND_W-1:0] prod_ff, prod_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [OUT_W-1:0]      row_j_ff, row_j_in;
   logic [STORE_AW-1:0]   base_ff, base_in;
   logic [OUT_W-1:0]      col_k_ff, col_k_in;
   logic [DIM_W-1:0]      col_c_ff, col_c_in;
   logic                  end_ff, end_in;
   logic                  last_ff, last_in;

   // effective geometry
   logic [DIM_W-1:0] sw_e;
   logic [DIM_W-1:0] sh_e;
   logic [OUT_W-1:0] ow_r;
   logic [OUT_W-1:0] ow_e;

   // shared multiply-add
   logic [DIM_W-1:0]           mul_a;
   logic [OUT_W-1:0]           mul_b;
   logic [DIM_W-1:0]           mul_c;
   logic [DIM_W+OUT_W-1:0]     mul_p;
   logic [DIVIDEND_W-1:0]      mul_out;

   // divider and store
   div_req_type           div_req;
   div_rsp_type           div_rsp;
   logic [DIVIDEND_W-1:0] quot;
   logic                  ram_wr_en;
   logic [STORE_AW-1:0]   ram_wr_addr;
   logic                  ram_rd_en;
   logic [STORE_AW-1:0]   ram_rd_addr;
   logic [LUMA_W-1:0]     ram_rd_data;

   // working signals
   logic                cfg_wr;
   logic [1:0]          cfg_idx;
   logic [9:0]          rgb_sum;
   logic [19:0]         luma_p;
   logic [LUMA_W-1:0]   luma;
   logic                hit;
   logic [DIM_W:0]      col_nx;
   logic [DIM_W:0]      row_nx;
   logic                wrap;
   logic [OUT_W:0]      k_nx;
   logic [LUMA_W-1:0]   lo;
   logic [LUMA_W-1:0]   hi;
   logic [LUMA_W-1:0]   lum_c;
   logic                fin_fetch;
   logic [LEVEL_W-1:0]  fin_level;
   logic [OUT_W:0]      rcol_nx;

   // geometry from the registers
   always_comb begin
      if (sw_cfg_ff == '0) begin
         sw_e = DIM_W'(1);
      end else if (sw_cfg_ff > MAX_SRC_DIM) begin
         sw_e = DIM_W'(MAX_SRC_DIM);
      end else begin
         sw_e = sw_cfg_ff;
      end
      if (sh_cfg_ff == '0) begin
         sh_e = DIM_W'(1);
      end else if (sh_cfg_ff > MAX_SRC_DIM) begin
         sh_e = DIM_W'(MAX_SRC_DIM);
      end else begin
         sh_e = sh_cfg_ff;
      end
      ow_r = (ow_cfg_ff == '0) ? OUT_W'(1) : ow_cfg_ff;
      if (DIM_W'(ow_r) > sw_e) begin
         ow_e = sw_e[OUT_W-1:0];
      end else if (ow_r > MAX_OUT_DIM) begin
         ow_e = OUT_W'(MAX_OUT_DIM);
      end else begin
         ow_e = ow_r;
      end
   end

   // multiply-add shared across the sequencer states
   assign mul_p   = mul_a * mul_b;
   assign mul_out = DIVIDEND_W'(mul_p) + DIVIDEND_W'(mul_c);

   // luma of the held pixel
   assign rgb_sum = {2'b00, item_ff.red} + {2'b00, item_ff.green} + {2'b00, item_ff.blue};
   assign luma_p  = rgb_sum * LUMA_RECIP;
   assign luma    = luma_p[LUMA_SHIFT+LUMA_W-1:LUMA_SHIFT];

   // config write decode
   assign cfg_wr  = psel & penable & pwrite;
   assign cfg_idx = paddr[CSR_AW-1:2];
   assign pready  = 1'b1;

   // register read-back
   always_comb begin
      unique case (cfg_idx)
         REG_SRC_WIDTH:  prdata = CSR_DW'(sw_cfg_ff);
         REG_SRC_HEIGHT: prdata = CSR_DW'(sh_cfg_ff);
         REG_OUT_WIDTH:  prdata = CSR_DW'(ow_cfg_ff);
         REG_CLAMP_MODE: prdata = CSR_DW'(clamp_ff);
         default:        prdata = '0;
      endcase
   end

   assign quot = div_rsp.quotient;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      sw_cfg_in     = sw_cfg_ff;
      sh_cfg_in     = sh_cfg_ff;
      ow_cfg_in     = ow_cfg_ff;
      clamp_in      = clamp_ff;
      geo_dirty_in  = geo_dirty_ff;
      track_ok_in   = track_ok_ff;
      row_ok_in     = row_ok_ff;
      col_ok_in     = col_ok_ff;
      adv_in        = adv_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      load_row_in   = load_row_ff;
      load_col_in   = load_col_ff;
      read_row_in   = read_row_ff;
      read_col_in   = read_col_ff;
      loaded_in     = loaded_ff;
      done_in       = done_ff;
      oh_in         = oh_ff;
      rsp_strobe_in = 1'b0;
      div_go_in     = 1'b0;
      item_in       = item_ff;
      rsp_item_in   = rsp_item_ff;
      prod_in       = prod_ff;
      divisor_in    = divisor_ff;
      row_j_in      = row_j_ff;
      base_in       = base_ff;
      col_k_in      = col_k_ff;
      col_c_in      = col_c_ff;
      end_in        = end_ff;
      last_in       = last_ff;
      mul_a         = '0;
      mul_b         = '0;
      mul_c         = '0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = base_ff + STORE_AW'(col_k_ff);
      ram_rd_en     = 1'b0;
      ram_rd_addr   = mul_out[STORE_AW-1:0];
      hit           = row_ok_ff & col_ok_ff & (col_c_ff == load_col_ff);
      col_nx        = {1'b0, load_col_ff} + (DIM_W+1)'(1);
      wrap          = col_nx >= (DIM_W+1)'(sw_e);
      row_nx        = wrap ? ({1'b0, load_row_ff} + (DIM_W+1)'(1)) : {1'b0, load_row_ff};
      k_nx          = {1'b0, col_k_ff} + (OUT_W+1)'(1);
      lo            = clamp_ff ? min_ff : '0;
      hi            = clamp_ff ? max_ff : LUMA_MAX;
      lum_c         = ram_rd_data;
      fin_fetch     = 1'b0;
      fin_level     = '0;
      rcol_nx       = {1'b0, read_col_ff} + (OUT_W+1)'(1);

      if (ram_rd_data < lo) begin
         lum_c = lo;
      end else if (ram_rd_data > hi) begin
         lum_c = hi;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in  = req_item;
               state_in = geo_dirty_ff ? ST_GEO_MUL : ST_DISPATCH;
            end
         end

         // output height = ow * sh / sw
         ST_GEO_MUL: begin
            mul_a      = sh_e;
            mul_b      = ow_e;
            prod_in    = mul_out;
            divisor_in = sw_e;
            div_go_in  = 1'b1;
            state_in   = ST_GEO_DIV;
         end

         ST_GEO_DIV: begin
            if (div_rsp.done) begin
               oh_in        = (quot > MAX_OUT_DIM) ? OUT_W'(MAX_OUT_DIM) : quot[OUT_W-1:0];
               geo_dirty_in = 1'b0;
               state_in     = ST_DISPATCH;
            end
         end

         ST_DISPATCH: begin
            if (item_ff.func == FUNC_FETCH) begin
               state_in = ST_FETCH;
            end else if (loaded_ff) begin
               state_in = ST_IDLE;
            end else if (!track_ok_ff) begin
               state_in = ST_ROW_MUL1;
            end else begin
               state_in = ST_LOAD;
            end
         end

         // first output row at or after this source row: ceil(row * oh / sh)
         ST_ROW_MUL1: begin
            if (oh_ff == '0) begin
               row_ok_in   = 1'b0;
               track_ok_in = 1'b1;
               state_in    = ST_LOAD;
            end else begin
               mul_a      = load_row_ff;
               mul_b      = oh_ff;
               mul_c      = sh_e - DIM_W'(1);
               prod_in    = mul_out;
               divisor_in = sh_e;
               div_go_in  = 1'b1;
               state_in   = ST_ROW_DIV1;
            end
         end

         ST_ROW_DIV1: begin
            if (div_rsp.done) begin
               if (quot >= DIVIDEND_W'(oh_ff)) begin
                  row_ok_in   = 1'b0;
                  track_ok_in = 1'b1;
                  state_in    = ST_LOAD;
               end else begin
                  row_j_in = quot[OUT_W-1:0];
                  state_in = ST_ROW_MUL2;
               end
            end
         end

         // check that output row j lands on this source row
         ST_ROW_MUL2: begin
            mul_a      = sh_e;
            mul_b      = row_j_ff;
            prod_in    = mul_out;
            divisor_in = DIVISOR_W'(oh_ff);
            div_go_in  = 1'b1;
            state_in   = ST_ROW_DIV2;
         end

         ST_ROW_DIV2: begin
            if (div_rsp.done) begin
               if (quot == DIVIDEND_W'(load_row_ff)) begin
                  row_ok_in = 1'b1;
                  state_in  = ST_ROW_BASE;
               end else begin
                  row_ok_in   = 1'b0;
                  track_ok_in = 1'b1;
                  state_in    = ST_LOAD;
               end
            end
         end

         // store address of the row start
         ST_ROW_BASE: begin
            mul_a    = DIM_W'(row_j_ff);
            mul_b    = ow_e;
            base_in  = mul_out[STORE_AW-1:0];
            adv_in   = 1'b0;
            state_in = ST_COL_MUL1;
         end

         // first output column at or after this source column
         ST_COL_MUL1: begin
            mul_a      = load_col_ff;
            mul_b      = ow_e;
            mul_c      = sw_e - DIM_W'(1);
            prod_in    = mul_out;
            divisor_in = sw_e;
            div_go_in  = 1'b1;
            state_in   = ST_COL_DIV1;
         end

         ST_COL_DIV1: begin
            if (div_rsp.done) begin
               if (quot >= DIVIDEND_W'(ow_e)) begin
                  col_ok_in   = 1'b0;
                  track_ok_in = 1'b1;
                  state_in    = ST_LOAD;
               end else begin
                  col_k_in = quot[OUT_W-1:0];
                  state_in = ST_COL_MUL2;
               end
            end
         end

         // source column that output column k samples
         ST_COL_MUL2: begin
            mul_a      = sw_e;
            mul_b      = col_k_ff;
            prod_in    = mul_out;
            divisor_in = DIVISOR_W'(ow_e);
            div_go_in  = 1'b1;
            state_in   = ST_COL_DIV2;
         end

         ST_COL_DIV2: begin
            if (div_rsp.done) begin
               col_c_in    = quot[DIM_W-1:0];
               col_ok_in   = 1'b1;
               track_ok_in = 1'b1;
               adv_in      = 1'b0;
               state_in    = adv_ff ? ST_IDLE : ST_LOAD;
            end
         end

         // keep the pixel if sampled, then step the load position
         ST_LOAD: begin
            state_in = ST_IDLE;
            if (hit) begin
               ram_wr_en = 1'b1;
               if (luma < min_ff) begin
                  min_in = luma;
               end
               if (luma > max_ff) begin
                  max_in = luma;
               end
            end
            if (wrap) begin
               load_col_in = '0;
               load_row_in = row_nx[DIM_W-1:0];
               track_ok_in = 1'b0;
            end else begin
               load_col_in = col_nx[DIM_W-1:0];
               if (hit) begin
                  if (k_nx >= (OUT_W+1)'(ow_e)) begin
                     col_ok_in = 1'b0;
                  end else begin
                     col_k_in = k_nx[OUT_W-1:0];
                     adv_in   = 1'b1;
                     state_in = ST_COL_MUL2;
                  end
               end
            end
            if (row_nx >= (DIM_W+1)'(sh_e)) begin
               loaded_in   = 1'b1;
               read_row_in = (oh_ff != '0) ? (oh_ff - OUT_W'(1)) : '0;
               read_col_in = '0;
               done_in     = (oh_ff == '0);
               state_in    = ST_IDLE;
            end
         end

         // readout position check and store read
         ST_FETCH: begin
            if (!loaded_ff || done_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_item_in   = '{level: '0, row_end: 1'b0, last: 1'b0, no_data: 1'b1};
               state_in      = ST_IDLE;
            end else if (read_row_ff >= oh_ff || read_col_ff >= ow_e) begin
               done_in       = 1'b1;
               rsp_strobe_in = 1'b1;
               rsp_item_in   = '{level: '0, row_end: 1'b0, last: 1'b0, no_data: 1'b1};
               state_in      = ST_IDLE;
            end else begin
               mul_a     = DIM_W'(read_row_ff);
               mul_b     = ow_e;
               mul_c     = DIM_W'(read_col_ff);
               ram_rd_en = 1'b1;
               end_in    = (read_col_ff == ow_e - OUT_W'(1));
               last_in   = (read_col_ff == ow_e - OUT_W'(1)) && (read_row_ff == '0);
               state_in  = ST_FETCH_RD;
            end
         end

         // scale the luma into the level range
         ST_FETCH_RD: begin
            if (hi > lo) begin
               mul_a      = DIM_W'(lum_c - lo);
               mul_b      = LEVEL_SCALE;
               prod_in    = mul_out;
               divisor_in = DIVISOR_W'(hi - lo);
               div_go_in  = 1'b1;
               state_in   = ST_FETCH_DIV;
            end else begin
               fin_fetch = 1'b1;
               fin_level = '0;
            end
         end

         ST_FETCH_DIV: begin
            if (div_rsp.done) begin
               fin_fetch = 1'b1;
               fin_level = quot[LEVEL_W-1:0];
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // deliver a level and step the readout position
      if (fin_fetch) begin
         rsp_strobe_in = 1'b1;
         rsp_item_in   = '{level: fin_level, row_end: end_ff, last: last_ff, no_data: 1'b0};
         state_in      = ST_IDLE;
         if (rcol_nx >= (OUT_W+1)'(ow_e)) begin
            read_col_in = '0;
            if (read_row_ff == '0) begin
               done_in = 1'b1;
            end else begin
               read_row_in = read_row_ff - OUT_W'(1);
            end
         end else begin
            read_col_in = rcol_nx[OUT_W-1:0];
         end
      end

      // register writes; geometry and trackers are rebuilt on the next item
      if (cfg_wr) begin
         geo_dirty_in = 1'b1;
         track_ok_in  = 1'b0;
         unique case (cfg_idx)
            REG_SRC_WIDTH:  sw_cfg_in = pwdata[DIM_W-1:0];
            REG_SRC_HEIGHT: sh_cfg_in = pwdata[DIM_W-1:0];
            REG_OUT_WIDTH:  ow_cfg_in = pwdata[OUT_W-1:0];
            REG_CLAMP_MODE: clamp_in  = pwdata[0];
            default:        geo_dirty_in = 1'b1;
         endcase
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sw_cfg_ff     <= SRC_WIDTH_RST;
         sh_cfg_ff     <= SRC_HEIGHT_RST;
         ow_cfg_ff     <= OUT_WIDTH_RST;
         clamp_ff      <= CLAMP_MODE_RST;
         geo_dirty_ff  <= 1'b1;
         track_ok_ff   <= 1'b0;
         row_ok_ff     <= 1'b0;
         col_ok_ff     <= 1'b0;
         adv_ff        <= 1'b0;
         min_ff        <= LUMA_MAX;
         max_ff        <= '0;
         load_row_ff   <= '0;
         load_col_ff   <= '0;
         read_row_ff   <= '0;
         read_col_ff   <= '0;
         loaded_ff     <= 1'b0;
         done_ff       <= 1'b0;
         oh_ff         <= OUT_W'(1);
         rsp_strobe_ff <= 1'b0;
         div_go_ff     <= 1'b0;
         rsp_item_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         sw_cfg_ff     <= sw_cfg_in;
         sh_cfg_ff     <= sh_cfg_in;
         ow_cfg_ff     <= ow_cfg_in;
         clamp_ff      <= clamp_in;
         geo_dirty_ff  <= geo_dirty_in;
         track_ok_ff   <= track_ok_in;
         row_ok_ff     <= row_ok_in;
         col_ok_ff     <= col_ok_in;
         adv_ff        <= adv_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
         load_row_ff   <= load_row_in;
         load_col_ff   <= load_col_in;
         read_row_ff   <= read_row_in;
         read_col_ff   <= read_col_in;
         loaded_ff     <= loaded_in;
         done_ff       <= done_in;
         oh_ff         <= oh_in;
         rsp_strobe_ff <= rsp_strobe_in;
         div_go_ff     <= div_go_in;
         rsp_item_ff   <= rsp_item_in;
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      prod_ff    <= prod_in;
      divisor_ff <= divisor_in;
      row_j_ff   <= row_j_in;
      base_ff    <= base_in;
      col_k_ff   <= col_k_in;
      col_c_ff   <= col_c_in;
      end_ff     <= end_in;
      last_ff    <= last_in;
   end

   // divider hookup
   assign div_req.start    = div_go_ff;
   assign div_req.dividend = prod_ff;
   assign div_req.divisor  = divisor_ff;

   gdc_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   gdc_ram #(
      .WIDTH (LUMA_W),
      .DEPTH (STORE_DEPTH)
   ) u_luma_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (luma),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

`default_nettype wire

// ===== hdl/gdc_checker.sv =====
// Port-level checker for the character-level downscaler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "gray_downscale_to_char_levels_macros.svh"

module gdc_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input gdc_pkg::rsp_type rsp_item
);

   import gdc_pkg::*;

   // an accepted beat always raises busy in the next cycle
   `GDC_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept did not raise busy")

   // a result beat lasts exactly one cycle
   `GDC_ASSERT_NEXT(a_strobe_pulse, clock, reset, rsp_strobe, !rsp_strobe, "result held over")

   // a result comes out as the block goes idle
   `GDC_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe, !busy, "result while busy")

   // an empty result carries no level or flags
   `GDC_ASSERT_NOW(a_no_data_clean, clock, reset, rsp_strobe && rsp_item.no_data, (rsp_item.level == '0) && !rsp_item.row_end && !rsp_item.last, "no_data beat with payload")

   // the final level is always a row end
   `GDC_ASSERT_NOW(a_last_row_end, clock, reset, rsp_strobe && rsp_item.last, rsp_item.row_end, "last without row_end")

endmodule

bind gray_downscale_to_char_levels gdc_checker u_checker (.*);

`default_nettype wire

// ===== bench/tb_gray_downscale_to_char_levels.sv =====
// Testbench for the character-level downscaler: one image loaded, read out and checked.
`timescale 1ns / 1ps

module tb_gray_downscale_to_char_levels;
   import gdc_pkg::*;

   localparam int DRAIN_CYCLES = 200;

   // Tracks registers, kept luma and read position; predicts each level beat
   class level_tracker;
      int unsigned     src_w_reg, src_h_reg, out_w_reg;
      bit              clamp_reg;
      bit [LUMA_W-1:0] luma_mem [STORE_DEPTH];
      int unsigned     lum_lo, lum_hi;
      int unsigned     load_row, load_col, read_row, read_col;
      bit              loaded, drained;
      rsp_type         levels_due[$];
      int unsigned     errors, checked, kept;

      function new();
         src_w_reg = SRC_WIDTH_RST;
         src_h_reg = SRC_HEIGHT_RST;
         out_w_reg = OUT_WIDTH_RST;
         clamp_reg = CLAMP_MODE_RST;
         lum_lo    = LUMA_MAX;
         lum_hi    = 0;
         load_row  = 0;
         load_col  = 0;
         read_row  = 0;
         read_col  = 0;
         loaded    = 1'b0;
         drained   = 1'b0;
         errors    = 0;
         checked   = 0;
         kept      = 0;
      endfunction

      function void set_reg(logic [1:0] idx, int unsigned val);
         case (idx)
            REG_SRC_WIDTH:  src_w_reg = val & 32'h1FFF;
            REG_SRC_HEIGHT: src_h_reg = val & 32'h1FFF;
            REG_OUT_WIDTH:  out_w_reg = val & 32'hFF;
            REG_CLAMP_MODE: clamp_reg = val[0];
            default: ;
         endcase
      endfunction

      function int unsigned clip_src(int unsigned v);
         if (v == 0) return 1;
         if (v > MAX_SRC_DIM) return MAX_SRC_DIM;
         return v;
      endfunction

      // Output grid for a given out_width value and the current source size
      function void grid(input int unsigned ow_reg, output int unsigned sw,
                         output int unsigned sh, output int unsigned ow,
                         output int unsigned oh);
         sw = clip_src(src_w_reg);
         sh = clip_src(src_h_reg);
         ow = (ow_reg == 0) ? 1 : ow_reg;
         if (ow > sw) ow = sw;
         if (ow > MAX_OUT_DIM) ow = MAX_OUT_DIM;
         oh = ow * sh / sw;
         if (oh > MAX_OUT_DIM) oh = MAX_OUT_DIM;
      endfunction

      // Is source index s (of n) hit by an output index (of m)?
      function bit picks(input int unsigned s, input int unsigned n, input int unsigned m,
                         output int unsigned idx);
         int unsigned j;
         idx = 0;
         if (m == 0) return 1'b0;
         j = (s * m + n - 1) / n;
         if (j >= m) return 1'b0;
         if (j * n / m != s) return 1'b0;
         idx = j;
         return 1'b1;
      endfunction

      // Would this out_width keep the read position inside the grid?
      function bit fits(int unsigned ow_reg);
         int unsigned sw, sh, ow, oh;
         grid(ow_reg, sw, sh, ow, oh);
         return (read_row < oh) && (read_col < ow);
      endfunction

      function int unsigned pending();
         return levels_due.size();
      endfunction

      // Accepted request beat: update state, queue the level it causes
      function void take_item(req_type it);
         int unsigned sw, sh, ow, oh, j, k, l, lo, hi, lev;
         rsp_type     r;
         grid(out_w_reg, sw, sh, ow, oh);
         if (it.func == FUNC_LOAD) begin
            if (loaded) return;
            if (picks(load_row, sh, oh, j) && picks(load_col, sw, ow, k)) begin
               l = (int'(it.red) + int'(it.green) + int'(it.blue)) / 3;
               luma_mem[(j * ow + k) % STORE_DEPTH] = l[LUMA_W-1:0];
               if (l < lum_lo) lum_lo = l;
               if (l > lum_hi) lum_hi = l;
               kept++;
            end
            load_col++;
            if (load_col >= sw) begin
               load_col = 0;
               load_row++;
            end
            if (load_row >= sh) begin
               loaded   = 1'b1;
               read_row = (oh != 0) ? oh - 1 : 0;
               read_col = 0;
               drained  = (oh == 0);
            end
            return;
         end
         r = '0;
         if (!loaded || drained) begin
            r.no_data = 1'b1;
         end else if (read_row >= oh || read_col >= ow) begin
            // grid shrank under the read position: readout over
            drained   = 1'b1;
            r.no_data = 1'b1;
         end else begin
            lo  = clamp_reg ? lum_lo : 0;
            hi  = clamp_reg ? lum_hi : LUMA_MAX;
            l   = luma_mem[(read_row * ow + read_col) % STORE_DEPTH];
            lev = 0;
            if (hi > lo) begin
               if (l < lo) l = lo;
               if (l > hi) l = hi;
               lev = (LEVEL_COUNT - 1) * (l - lo) / (hi - lo);
            end
            r.level   = lev[LEVEL_W-1:0];
            r.row_end = (read_col == ow - 1);
            r.last    = r.row_end && (read_row == 0);
            read_col++;
            if (read_col >= ow) begin
               read_col = 0;
               if (read_row == 0) drained = 1'b1;
               else read_row--;
            end
         end
         levels_due.push_back(r);
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) $display("mismatch: %s", msg);
      endfunction

      // Result beat: compare with the oldest expected level
      function void check_level(rsp_type got);
         rsp_type want;
         checked++;
         if (levels_due.size() == 0) begin
            flag($sformatf("result with none expected: level %0d row_end %b last %b no_data %b",
                           got.level, got.row_end, got.last, got.no_data));
            return;
         end
         want = levels_due.pop_front();
         if (got.level !== want.level || got.row_end !== want.row_end ||
             got.last !== want.last || got.no_data !== want.no_data)
            flag($sformatf({"result %0d: expected level %0d row_end %b last %b no_data %b, ",
                            "got level %0d row_end %b last %b no_data %b"}, checked,
                           want.level, want.row_end, want.last, want.no_data,
                           got.level, got.row_end, got.last, got.no_data));
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   req_type           req_item = '0;
   logic              rsp_strobe;
   rsp_type           rsp_item;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [CSR_DW-1:0] pwdata = '0;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   level_tracker levels;
   int unsigned  burst_left = 0;

   gray_downscale_to_char_levels dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always #5 clock = ~clock;

   // Result beats are taken at the edge that ends their cycle
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         levels.check_level(rsp_item);
   end

   // Safety net against a hang
   initial begin
      #(50_000_000);
      $display("[FAIL] regression broken");
      $finish;
   end

   // One request beat; bursts of random length separated by random gaps
   task automatic send_beat(input req_type it);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy !== 1'b0);
      levels.take_item(it);
   endtask

   task automatic fetch();
      req_type it;
      it      = req_type'($urandom);
      it.func = FUNC_FETCH;
      send_beat(it);
   endtask

   task automatic load_random();
      req_type it;
      it      = req_type'($urandom);
      it.func = FUNC_LOAD;
      send_beat(it);
   endtask

   // Readout fetch with the odd stray load mixed in (ignored once loaded)
   task automatic fetch_or_noise();
      if ($urandom_range(0, 9) == 0) load_random();
      fetch();
   endtask

   // Hold the sender until every level is back and the block has gone quiet
   task automatic settle();
      start <= 1'b0;
      burst_left = 0;
      while (levels.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register write: setup cycle, then access until pready
   task automatic write_reg(input logic [1:0] idx, input int unsigned val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      levels.set_reg(idx, val);
      @(posedge clock);
   endtask

   // Pixel whose components add up to a fixed total
   function automatic req_type flat_pixel(int unsigned total);
      req_type     p;
      int unsigned rest;
      p.func  = FUNC_LOAD;
      p.red   = 8'($urandom_range(total > 510 ? total - 510 : 0, total < 255 ? total : 255));
      rest    = total - p.red;
      p.green = 8'($urandom_range(rest > 255 ? rest - 255 : 0, rest < 255 ? rest : 255));
      p.blue  = 8'(rest - p.green);
      return p;
   endfunction

   function automatic req_type corner_pixel(int unsigned i);
      logic [23:0] rgb;
      case (i)
         0: rgb = 24'h000000;
         1: rgb = 24'hFFFFFF;
         2: rgb = 24'hFF0000;
         3: rgb = 24'h00FF00;
         4: rgb = 24'h0000FF;
         default: rgb = 24'h807F81;
      endcase
      return req_type'({FUNC_LOAD, rgb});
   endfunction

   initial begin
      int unsigned sw, sh, ow_val, try_ow, pick, n_out, luma_total, idx;
      int unsigned g_sw, g_sh, g_ow, g_oh;
      bit          clamp, flat;
      levels = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Nothing loaded yet: every fetch answers no_data, whatever the registers hold
      repeat (2) fetch();
      settle();
      write_reg(REG_SRC_WIDTH, 0);
      write_reg(REG_SRC_HEIGHT, 32'h1FFF);
      write_reg(REG_OUT_WIDTH, MAX_OUT_DIM);
      write_reg(REG_CLAMP_MODE, 0);
      repeat (2) fetch();
      settle();
      write_reg(REG_SRC_WIDTH, 32'h1FFF);
      write_reg(REG_SRC_HEIGHT, 0);
      write_reg(REG_OUT_WIDTH, 0);
      write_reg(REG_CLAMP_MODE, 1);
      repeat (2) fetch();
      settle();

      // Image geometry: narrow images can reach the output height cap
      if ($urandom_range(0, 5) == 0) sw = $urandom_range(1, 2);
      else sw = $urandom_range(3, 40);
      sh   = $urandom_range(700 / sw, 1000 / sw);
      pick = $urandom_range(0, 9);
      if (pick == 0) ow_val = MAX_OUT_DIM;
      else if (pick == 1 && sh >= sw) ow_val = 0;
      else ow_val = $urandom_range((sw + sh - 1) / sh, sw);
      clamp      = 1'($urandom_range(0, 1));
      flat       = ($urandom_range(0, 3) == 0);
      luma_total = $urandom_range(0, 765);
      write_reg(REG_SRC_WIDTH, (sw == 1 && $urandom_range(0, 1) == 1) ? 0 : sw);
      write_reg(REG_SRC_HEIGHT, sh);
      write_reg(REG_OUT_WIDTH, ow_val);
      write_reg(REG_CLAMP_MODE, 32'(clamp));

      // Load the image, early fetches sprinkled in
      for (idx = 0; idx < sw * sh; idx++) begin
         if ($urandom_range(0, 11) == 0) fetch();
         if (flat) send_beat(flat_pixel(luma_total));
         else if (idx < 6) send_beat(corner_pixel(idx));
         else load_random();
      end

      // Readout in phases, contrast mode flipped in between
      levels.grid(levels.out_w_reg, g_sw, g_sh, g_ow, g_oh);
      n_out = g_oh * g_ow;
      repeat (n_out / 2) fetch_or_noise();
      settle();
      write_reg(REG_CLAMP_MODE, 32'(!clamp));
      repeat (n_out / 4) fetch_or_noise();
      settle();

      // Narrower output mid-readout; now and then one that cuts the readout short
      ow_val = g_ow;
      if ($urandom_range(0, 3) == 0) begin
         ow_val = $urandom_range(0, g_ow);
      end else begin
         repeat (8) begin
            try_ow = $urandom_range(0, g_ow);
            if (levels.fits(try_ow)) ow_val = try_ow;
         end
      end
      write_reg(REG_OUT_WIDTH, ow_val);
      while (!levels.drained) fetch_or_noise();

      // After the readout: no_data only
      repeat ($urandom_range(40, 80)) fetch_or_noise();
      settle();
      write_reg(REG_SRC_WIDTH, MAX_SRC_DIM);
      write_reg(REG_SRC_HEIGHT, MAX_SRC_DIM);
      write_reg(REG_OUT_WIDTH, 1);
      write_reg(REG_CLAMP_MODE, 0);
      repeat (6) fetch_or_noise();
      settle();

      $display("covered: %0dx%0d %s source, %0d pixels kept, %0dx%0d output grid",
               sw, sh, flat ? "flat" : "varied", levels.kept, g_ow, g_oh);
      $display("covered: %0d level beats checked, %0d failures", levels.checked,
               levels.errors);
      if (levels.errors == 0 && levels.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
